>>> rtl/pms_pkg.sv
package pms_pkg;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] PLUS_CHAR = 8'h2B;

  localparam logic [1:0] CFG_CHARS_LOW  = 2'd0;
  localparam logic [1:0] CFG_CHARS_HIGH = 2'd1;
  localparam logic [1:0] CFG_LENGTH     = 2'd2;

  // Update wave passed from one row cell to the next.
  typedef struct packed {
    logic       fire;
    logic       old_bit;
    logic       new_bit;
    logic       new2_bit;
    logic [7:0] pchar;
    logic       pvalid;
  } wave_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

endpackage

>>> rtl/pms_cell.sv
module pms_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     pat_char,
  input  logic           mode,
  input  logic [7:0]     text_char,
  input  pms_pkg::wave_t wave_in,
  output pms_pkg::wave_t wave_out,
  output logic           col_bit
);

  logic           col_r;
  logic           col_nxt;
  pms_pkg::wave_t wave_r;
  pms_pkg::wave_t wave_nxt;
  logic           is_star;
  logic           is_quant;
  logic           eq;
  logic           upd;

  assign is_star  = (pat_char == pms_pkg::STAR_CHAR);
  assign is_quant = is_star || (pat_char == pms_pkg::PLUS_CHAR);
  // A leading quantifier has no preceding character to compare.
  assign eq       = wave_in.pvalid && (wave_in.pchar == text_char);

  always_comb begin
    if (!mode) begin
      upd = is_star && wave_in.pvalid && wave_in.new2_bit;
    end else if (is_quant) begin
      upd = wave_in.new_bit || (eq && (wave_in.old_bit || col_r)) ||
            (is_star && wave_in.new2_bit);
    end else begin
      upd = (pat_char == text_char) && wave_in.old_bit;
    end
    col_nxt           = wave_in.fire ? upd : col_r;
    wave_nxt.fire     = wave_in.fire;
    wave_nxt.old_bit  = col_r;
    wave_nxt.new_bit  = upd;
    wave_nxt.new2_bit = wave_in.new_bit;
    wave_nxt.pchar    = pat_char;
    wave_nxt.pvalid   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 1'b0;
      wave_r.fire <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      wave_r.fire <= wave_nxt.fire;
    end
    wave_r.old_bit  <= wave_nxt.old_bit;
    wave_r.new_bit  <= wave_nxt.new_bit;
    wave_r.new2_bit <= wave_nxt.new2_bit;
    wave_r.pchar    <= wave_nxt.pchar;
    wave_r.pvalid   <= wave_nxt.pvalid;
  end

  assign wave_out = wave_r;
  assign col_bit  = col_r;

endmodule

>>> rtl/pattern_match_star_plus.sv
// The update wave walks the row cells one per cycle, since each row depends on
// the rows just below; a new word enters only once the last result has left
// the rows. The output register lets a new word enter while a result waits.
// Reset (synchronous, rst_n low): row zero set; other rows' column bits and fire
// flags, the pattern, length, state and output valid clear.
module pattern_match_star_plus #(
  parameter int PATTERN_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_text_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (IW > 5) ? IW : 5;

  logic [127:0]       pat_r;
  logic [4:0]         len_r;
  logic               col0_r;
  logic               mode_r;
  logic [7:0]         char_r;
  pms_pkg::state_t    state_r;
  pms_pkg::state_t    state_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_matched_r;
  logic               load_out;
  logic               accept;
  logic               out_free;
  logic               done;
  logic [PATTERN_MAX:0] col;
  pms_pkg::wave_t     wave [0:PATTERN_MAX];
  pms_pkg::wave_t     wave0_r;
  logic [CW-1:0]      len_ext;
  logic [CW-1:0]      used_len;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != pms_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign done      = wave[PATTERN_MAX].fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pms_pkg::CFG_CHARS_LOW:  pat_r[63:0]   <= cfg_data;
        pms_pkg::CFG_CHARS_HIGH: pat_r[127:64] <= cfg_data;
        pms_pkg::CFG_LENGTH:     len_r         <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Row zero starts the wave; rows below zero read as clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r       <= 1'b1;
      wave0_r.fire <= 1'b0;
    end else begin
      wave0_r.fire <= accept;
      if (accept) begin
        col0_r <= !in_mode;
      end
    end
    wave0_r.old_bit  <= col0_r;
    wave0_r.new_bit  <= !in_mode;
    wave0_r.new2_bit <= 1'b0;
    wave0_r.pchar    <= 8'h00;
    wave0_r.pvalid   <= 1'b0;
    if (accept) begin
      mode_r <= in_mode;
      char_r <= in_text_char;
    end
  end

  assign wave[0] = wave0_r;
  assign col[0]  = col0_r;

  genvar gi;
  generate
    for (gi = 1; gi <= PATTERN_MAX; gi++) begin : g_row
      logic [7:0] pchar;
      if (gi <= 16) begin : g_stored
        assign pchar = pat_r[8*(gi-1) +: 8];
      end else begin : g_zero
        assign pchar = 8'h00;
      end
      pms_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .pat_char  (pchar),
        .mode      (mode_r),
        .text_char (char_r),
        .wave_in   (wave[gi-1]),
        .wave_out  (wave[gi]),
        .col_bit   (col[gi])
      );
    end
  endgenerate

  assign len_ext  = CW'(len_r);
  assign used_len = (len_ext > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : len_ext;

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      pms_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pms_pkg::ST_RUN;
        end
      end
      pms_pkg::ST_RUN: begin
        if (done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = pms_pkg::ST_IDLE;
          end else begin
            state_nxt = pms_pkg::ST_HOLD;
          end
        end
      end
      pms_pkg::ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = pms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pms_pkg::ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pms_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      out_matched_r <= col[used_len[IW-1:0]];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule
